// ===== hdl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude unit.
// Used by the interfaces, the front end, the queue, the back end and the top level.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

  localparam int CH_W = 8;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic           last;
    pix_t [8:0]     px;
  } win_t;

endpackage

// ===== hdl/sem_pix_if.sv =====
// Input pixel channel of the Sobel edge magnitude unit.
// Depends on sem_pkg for the channel width.
interface sem_pix_if
  import sem_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;

  modport source (output valid, req_type, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, req_type, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

// ===== hdl/sem_edge_if.sv =====
// Result channel of the Sobel edge magnitude unit.
// Depends on sem_pkg for the channel width.
interface sem_edge_if
  import sem_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] edge_red;
  logic [CH_W-1:0] edge_green;
  logic [CH_W-1:0] edge_blue;
  logic            frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// ===== hdl/sem_front.sv =====
// Front end: accepts pixel transactions, keeps the line store, the 3x3 window
// and the frame counters, and pushes masked windows into the queue. Uses sem_pkg.
module sem_front
  import sem_pkg::*;
#(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sem_pix_if.sink              pix,
  input  logic                 q_full_i,
  output logic                 push_o,
  output win_t                 win_o
);

  localparam int CW = $clog2(MaxWidth + 1);
  localparam int HW = $clog2(MaxHeight + 1);
  localparam int RW = $clog2(MaxHeight + 2);
  localparam int AW = $clog2(MaxWidth);
  localparam int RstW = (RST_WIDTH > MaxWidth) ? MaxWidth : RST_WIDTH;
  localparam int RstH = (RST_HEIGHT > MaxHeight) ? MaxHeight : RST_HEIGHT;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] cfg_w_q;
  logic [HW-1:0] cfg_h_q;
  logic [CW-1:0] icol_q;
  logic [RW-1:0] irow_q;
  logic [CW-1:0] ocol_q;
  logic [HW-1:0] orow_q;
  pix_t          win_q [9];
  pix_t          win_d [9];
  pix_t          pix_q;
  logic [47:0]   rd_q;
  logic [47:0]   mem [MaxWidth];

  logic          accept;
  logic [CW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [CW:0]   icol_inc;
  logic          icol_wrap;
  logic          emit;
  logic          top_ok, bot_ok, left_ok, right_ok, last;
  logic          row_ok, col_ok;

  assign pix.ready = (state_q == ST_IDLE) && !q_full_i;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    if (cfg_data_i == '0) begin
      w_clamp = CW'(1);
    end else if (int'(cfg_data_i) > MaxWidth) begin
      w_clamp = CW'(MaxWidth);
    end else begin
      w_clamp = CW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_clamp = HW'(1);
    end else if (int'(cfg_data_i) > MaxHeight) begin
      h_clamp = HW'(MaxHeight);
    end else begin
      h_clamp = HW'(cfg_data_i);
    end
  end

  assign icol_inc  = {1'b0, icol_q} + (CW+1)'(1);
  assign icol_wrap = icol_inc >= {1'b0, cfg_w_q};
  assign emit      = (irow_q >= RW'(2)) || ((irow_q == RW'(1)) && (icol_q != '0));
  assign top_ok    = orow_q != '0;
  assign left_ok   = ocol_q != '0;
  assign bot_ok    = ({1'b0, orow_q} + (HW+1)'(1)) < {1'b0, cfg_h_q};
  assign right_ok  = ({1'b0, ocol_q} + (CW+1)'(1)) < {1'b0, cfg_w_q};
  assign last      = !bot_ok && !right_ok;

  always_comb begin
    row_ok = 1'b0;
    col_ok = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        win_d[r*3+c] = win_q[r*3+c+1];
      end
    end
    win_d[2] = pix_t'(rd_q[47:24]);
    win_d[5] = pix_t'(rd_q[23:0]);
    win_d[8] = pix_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_ok = (r == 0) ? top_ok : ((r == 2) ? bot_ok : 1'b1);
        col_ok = (c == 0) ? left_ok : ((c == 2) ? right_ok : 1'b1);
        win_o.px[r*3+c] = (row_ok && col_ok) ? win_d[r*3+c] : '0;
      end
    end
    win_o.last = last;
  end

  assign push_o = (state_q == ST_RD) && emit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[icol_q[AW-1:0]];
      pix_q <= pix.req_type ? '0 : {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
    end
    if (state_q == ST_RD) begin
      mem[icol_q[AW-1:0]] <= {rd_q[23:0], pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_w_q <= CW'(RstW);
      cfg_h_q <= HW'(RstH);
      icol_q  <= '0;
      irow_q  <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WIDTH: begin
            cfg_w_q <= w_clamp;
          end
          CFG_IDX_HEIGHT: begin
            cfg_h_q <= h_clamp;
          end
          default: begin
          end
        endcase
        icol_q <= '0;
        irow_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else if (state_q == ST_RD) begin
        for (int i = 0; i < 9; i++) begin
          win_q[i] <= win_d[i];
        end
        if (emit && last) begin
          icol_q <= '0;
          irow_q <= '0;
          ocol_q <= '0;
          orow_q <= '0;
        end else begin
          if (icol_wrap) begin
            icol_q <= '0;
            irow_q <= irow_q + RW'(1);
          end else begin
            icol_q <= icol_inc[CW-1:0];
          end
          if (emit) begin
            if (right_ok) begin
              ocol_q <= ocol_q + CW'(1);
            end else begin
              ocol_q <= '0;
              orow_q <= orow_q + HW'(1);
            end
          end
        end
      end
    end
  end

  a_accept_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RD))
    else $error("accepted transaction did not enter the read phase");

  a_read_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_IDLE))
    else $error("read phase lasted more than one cycle");

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (!q_full_i && $past(accept)))
    else $error("window pushed without room or without a transaction");

endmodule

// ===== hdl/sem_fifo.sv =====
// Two-entry queue of masked windows between the front end and the back end.
// Uses sem_pkg for the window type.
module sem_fifo
  import sem_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  win_t data_i,
  output logic full_o,
  input  logic pop_i,
  output win_t data_o,
  output logic empty_o
);

  win_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/sem_back.sv =====
// Back end: Sobel gradients, squared magnitude, bit-pair square root with
// rounding and clamping, and the result register. Uses sem_pkg and sem_edge_if.
module sem_back
  import sem_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  win_t       win_i,
  input  logic       empty_i,
  output logic       pop_o,
  sem_edge_if.source res
);

  localparam int GW = 11;
  localparam int SQ_W = 22;
  localparam int RT_W = 11;
  localparam int RM_W = 12;
  localparam logic [3:0] LAST_STEP = 4'd10;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_MUL  = 2'd1;
  localparam logic [1:0] BK_ROOT = 2'd2;
  localparam logic [1:0] BK_DONE = 2'd3;

  logic [1:0]            state_q;
  logic signed [GW-1:0]  gx_q [3];
  logic signed [GW-1:0]  gy_q [3];
  logic [SQ_W-1:0]       sq_q [3];
  logic [RT_W-1:0]       root_q [3];
  logic [RM_W-1:0]       rem_q [3];
  logic [3:0]            step_q;
  logic                  last_q;
  logic                  out_vld_q;
  logic [CH_W-1:0]       out_q [3];
  logic                  out_last_q;

  logic signed [GW-1:0]  v [3][9];
  logic signed [GW-1:0]  gx_c [3];
  logic signed [GW-1:0]  gy_c [3];
  logic signed [SQ_W-1:0] px2 [3];
  logic signed [SQ_W-1:0] py2 [3];
  logic [RM_W+1:0]       rem_sh [3];
  logic [RM_W+1:0]       trial [3];
  logic                  ge [3];
  logic [RM_W-1:0]       rnd [3];
  logic [CH_W-1:0]       mag [3];
  logic                  load;

  assign pop_o = (state_q == BK_IDLE) && !empty_i;
  assign load  = (state_q == BK_DONE) && (!out_vld_q || res.ready);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v[0][i] = $signed({3'b000, win_i.px[i].red});
      v[1][i] = $signed({3'b000, win_i.px[i].green});
      v[2][i] = $signed({3'b000, win_i.px[i].blue});
    end
    for (int k = 0; k < 3; k++) begin
      gx_c[k] = v[k][2] - v[k][0] + ((v[k][5] - v[k][3]) <<< 1) + v[k][8] - v[k][6];
      gy_c[k] = v[k][6] - v[k][0] + ((v[k][7] - v[k][1]) <<< 1) + v[k][8] - v[k][2];
      px2[k] = SQ_W'(gx_q[k]) * SQ_W'(gx_q[k]);
      py2[k] = SQ_W'(gy_q[k]) * SQ_W'(gy_q[k]);
      rem_sh[k] = {rem_q[k], sq_q[k][SQ_W-1:SQ_W-2]};
      trial[k]  = {1'b0, root_q[k], 2'b01};
      ge[k]     = rem_sh[k] >= trial[k];
      rnd[k]    = {1'b0, root_q[k]} + RM_W'(rem_q[k] > {1'b0, root_q[k]});
      mag[k]    = (rnd[k] > RM_W'(255)) ? {CH_W{1'b1}} : rnd[k][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          gx_q[k] <= gx_c[k];
          gy_q[k] <= gy_c[k];
        end
        last_q <= win_i.last;
      end
      BK_MUL: begin
        for (int k = 0; k < 3; k++) begin
          sq_q[k]   <= $unsigned(px2[k]) + $unsigned(py2[k]);
          root_q[k] <= '0;
          rem_q[k]  <= '0;
        end
      end
      BK_ROOT: begin
        for (int k = 0; k < 3; k++) begin
          sq_q[k]   <= sq_q[k] << 2;
          root_q[k] <= {root_q[k][RT_W-2:0], ge[k]};
          rem_q[k]  <= ge[k] ? RM_W'(rem_sh[k] - trial[k]) : RM_W'(rem_sh[k]);
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= mag[k];
      end
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      case (state_q)
        BK_IDLE: begin
          if (pop_o) begin
            state_q <= BK_MUL;
          end
        end
        BK_MUL: begin
          step_q  <= '0;
          state_q <= BK_ROOT;
        end
        BK_ROOT: begin
          step_q <= step_q + 4'd1;
          if (step_q == LAST_STEP) begin
            state_q <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (load) begin
            state_q <= BK_IDLE;
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (res.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign res.valid      = out_vld_q;
  assign res.edge_red   = out_q[0];
  assign res.edge_green = out_q[1];
  assign res.edge_blue  = out_q[2];
  assign res.frame_end  = out_last_q;

endmodule

// ===== hdl/sobel_edge_magnitude_rgb_unit.sv =====
// Sobel edge magnitude unit for an RGB raster stream. The front end takes a new
// pixel transaction only when the queue has room and the last one is through its
// line store read, then write, and the back end works on one window at a time,
// through an 11-step square root that each of the three colour channels runs in
// its own registers. A result trails its pixel by one row and one column, so the
// host sends frame width plus one drain transactions after the last pixel. The
// line store needs no clearing after reset.
module sobel_edge_magnitude_rgb_unit
  import sem_pkg::*;
#(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sem_pix_if.sink              pix_i,
  sem_edge_if.source           res_o
);

  logic push, full, pop, empty;
  win_t win_in, win_out;

  sem_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix        (pix_i),
    .q_full_i   (full),
    .push_o     (push),
    .win_o      (win_in)
  );

  sem_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (win_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (win_out),
    .empty_o (empty)
  );

  sem_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .win_i   (win_out),
    .empty_i (empty),
    .pop_o   (pop),
    .res     (res_o)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sobel_edge_magnitude_rgb_unit, with its own edge predictor.
// Depends on sem_pkg and on the sem_pix_if and sem_edge_if interfaces.
module tb;
  import sem_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int IDLE_WAIT    = 200;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } edge_t;

  class edge_scoreboard;
    pix_t  older_line[MAX_WIDTH_DEF];
    pix_t  newer_line[MAX_WIDTH_DEF];
    pix_t  win[3][3];
    int    in_col, in_row, out_col, out_row;
    int    width, height;
    edge_t pending_edges[$];
    int    errors, results, frames;

    function new();
      width  = RST_WIDTH;
      height = RST_HEIGHT;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[c, r]) win[c][r] = '0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, int value);
      int v;
      v = value & 'hfff;
      if (v == 0) v = 1;
      if (idx == CFG_IDX_WIDTH) begin
        width = (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
      end else begin
        height = (v > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : v;
      end
      restart();
    endfunction

    function int rounded_root(int s);
      int n;
      int t;
      n = 0;
      for (int b = 11; b >= 0; b--) begin
        t = n | (1 << b);
        if (t * t <= s) n = t;
      end
      if (s - n * n > n) n++;
      return n;
    endfunction

    function logic [CH_W-1:0] channel_mag(int ch, bit keep[3][3]);
      int gx, gy, v, n;
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (keep[r][c]) begin
            case (ch)
              0: v = win[c][r].red;
              1: v = win[c][r].green;
              default: v = win[c][r].blue;
            endcase
            gx += v * (c - 1) * ((r == 1) ? 2 : 1);
            gy += v * (r - 1) * ((c == 1) ? 2 : 1);
          end
        end
      end
      n = rounded_root(gx * gx + gy * gy);
      return (n > 255) ? 8'd255 : n[CH_W-1:0];
    endfunction

    function void note_input(logic is_drain, pix_t p);
      pix_t  px, older, newer;
      bit    produce, row_ok, col_ok;
      bit    keep[3][3];
      edge_t e;
      px    = is_drain ? pix_t'('0) : p;
      older = older_line[in_col];
      newer = newer_line[in_col];
      older_line[in_col] = newer;
      newer_line[in_col] = px;
      for (int c = 0; c < 2; c++)
        for (int r = 0; r < 3; r++) win[c][r] = win[c+1][r];
      win[2][0] = older;
      win[2][1] = newer;
      win[2][2] = px;
      produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= width) begin
        in_col = 0;
        in_row++;
      end
      if (!produce) return;
      for (int r = 0; r < 3; r++) begin
        row_ok = (r == 0) ? (out_row >= 1) : (r == 2) ? (out_row + 1 < height) : 1'b1;
        for (int c = 0; c < 3; c++) begin
          col_ok = (c == 0) ? (out_col >= 1) : (c == 2) ? (out_col + 1 < width) : 1'b1;
          keep[r][c] = row_ok && col_ok;
        end
      end
      e.red       = channel_mag(0, keep);
      e.green     = channel_mag(1, keep);
      e.blue      = channel_mag(2, keep);
      e.frame_end = (out_row + 1 >= height) && (out_col + 1 >= width);
      pending_edges.push_back(e);
      if (e.frame_end) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= width) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(edge_t got);
      edge_t want;
      results++;
      if (pending_edges.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result r=%0d g=%0d b=%0d end=%0b",
                                   got.red, got.green, got.blue, got.frame_end);
        return;
      end
      want = pending_edges.pop_front();
      if (got.frame_end === 1'b1 && want.frame_end) frames++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                   want.red, want.green, want.blue, want.frame_end,
                   got.red, got.green, got.blue, got.frame_end);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int cycles = 0;
  int sent = 0;
  int drains = 0;
  int cfg_writes = 0;
  bit hold_req = 1'b0;
  edge_scoreboard sb = new();

  sem_pix_if  pix_ch ();
  sem_edge_if edge_ch ();

  sobel_edge_magnitude_rgb_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_ch),
    .res_o      (edge_ch)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic is_drain, pix_t p);
    int gap;
    gap = ((sent / 150) % 5 == 0) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.req_type    <= is_drain;
    pix_ch.pixel_red   <= p.red;
    pix_ch.pixel_green <= p.green;
    pix_ch.pixel_blue  <= p.blue;
    do @(posedge clk_i); while (!pix_ch.ready);
    sb.note_input(is_drain, p);
    sent++;
    if (is_drain) drains++;
  endtask

  task automatic send_frame(int w, int h, int drain_pct, int ignored_pct);
    for (int i = 0; i < w * h; i++) begin
      send_item($urandom_range(0, 99) < drain_pct, pix_t'($urandom));
    end
    for (int i = 0; i <= w; i++) begin
      send_item(!($urandom_range(0, 99) < ignored_pct), pix_t'($urandom));
    end
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, int value);
    pix_ch.valid <= 1'b0;
    while (sb.pending_edges.size() > 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk_i);
    sb.set_size(idx, value);
    cfg_writes++;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    int quiet;
    edge_t got;
    edge_ch.ready <= 1'b0;
    quiet = 0;
    wait (rst_ni === 1'b1);
    forever begin
      quiet++;
      gap = ((quiet / 120) % 4 == 0) ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold_req = 1'b0;
        edge_ch.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (gap > 0) begin
        edge_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      edge_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!edge_ch.valid);
      got.red       = edge_ch.edge_red;
      got.green     = edge_ch.edge_green;
      got.blue      = edge_ch.edge_blue;
      got.frame_end = edge_ch.frame_end;
      sb.check_result(got);
    end
  end

  initial begin
    int w, h;
    bit held;
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_IDX_WIDTH;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.req_type    <= 1'b0;
    pix_ch.pixel_red   <= '0;
    pix_ch.pixel_green <= '0;
    pix_ch.pixel_blue  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few pixels at the reset size, then abandoned by a register write.
    for (int i = 0; i < 5; i++) send_item(1'b0, pix_t'($urandom));
    write_size(CFG_IDX_WIDTH, 3);
    write_size(CFG_IDX_HEIGHT, 3);
    // Checkerboard of full-scale and zero pixels, with a drain inside the frame
    // and a pixel in the drain part that must be ignored.
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(1'b1, pix_t'('1));
      else send_item(1'b0, (i % 2) ? pix_t'('1) : pix_t'('0));
    end
    send_item(1'b0, pix_t'('1));
    for (int i = 0; i < 3; i++) send_item(1'b1, pix_t'('0));
    write_size(CFG_IDX_WIDTH, 0);
    write_size(CFG_IDX_HEIGHT, 0);
    send_item(1'b0, pix_t'('1));
    send_item(1'b1, '0);
    send_item(1'b1, '0);
    // Oversized sizes are clamped to the maximum; both frames are abandoned part way.
    write_size(CFG_IDX_WIDTH, 4095);
    write_size(CFG_IDX_HEIGHT, 1);
    for (int i = 0; i < 120; i++) send_item(1'b0, pix_t'($urandom));
    write_size(CFG_IDX_WIDTH, 1);
    write_size(CFG_IDX_HEIGHT, 4095);
    for (int i = 0; i < 150; i++) send_item(1'($urandom_range(0, 1)), pix_t'($urandom));

    held = 1'b0;
    for (int k = sent; k < 1750; k += 0) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if (w != sb.width || $urandom_range(0, 3) == 0) write_size(CFG_IDX_WIDTH, w);
      if (h != sb.height || $urandom_range(0, 3) == 0) write_size(CFG_IDX_HEIGHT, h);
      if (!held && k > 600) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        send_frame(w, h, 5, 10);
        k += w * h + w + 1;
      end else begin
        for (int i = $urandom_range(1, 3 * w * h); i > 0; i--) begin
          send_item(1'($urandom_range(0, 1)), pix_t'($urandom));
          k++;
        end
        write_size(($urandom_range(0, 1) == 0) ? CFG_IDX_WIDTH : CFG_IDX_HEIGHT, w);
      end
    end

    pix_ch.valid <= 1'b0;
    while (sb.pending_edges.size() > 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    $display("Sent %0d transactions (%0d drains) over %0d register writes.",
             sent, drains, cfg_writes);
    $display("Checked %0d results and %0d complete frames; %0d mismatches.",
             sb.results, sb.frames, sb.errors);
    if (sb.errors == 0 && sb.pending_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sem_pkg.sv
hdl/sem_pix_if.sv
hdl/sem_edge_if.sv
hdl/sem_front.sv
hdl/sem_fifo.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude_rgb_unit.sv
verif/tb.sv
